/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ccon_pkg.sv */
package ccon_pkg;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 8;

  localparam logic [CFG_AW-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_AW-1:0] REG_COLS = 1'd1;

  localparam logic [6:0] ROWS_RESET = 7'd30;
  localparam logic [7:0] COLS_RESET = 8'd80;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_NUL,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_FF,
    OP_CHAR
  } op_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [6:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic       scrolled;
  } rsp_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

endpackage

/* rtl/text_console_char_engine.sv */
// Text console engine: an item is taken when start is high and busy is low, and
// each item gives exactly one result, shown for one cycle with done_o; the
// receiver cannot stall it. Items wait in a two-entry queue while the sequencer
// works, one store cell per cycle, with separate read and write ports. A read
// goes from the queue through a store read to its result, a printable character
// writes one cell; LF blanks the cells from the cursor column to the end of the row
// (none when the cursor sits on the row below the last), BS blanks one cell, FF
// blanks rows x columns cells, and a scroll copies each row below the first up
// by one row and then blanks the bottom row. After reset, busy stays high while
// all MAX_ROWS x MAX_COLS cells of the store are blanked; configuration writes
// are taken during that time.
module text_console_char_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ccon_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [ccon_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        start,
  input  ccon_pkg::req_t              req_i,
  output logic                        busy,
  output logic                        done_o,
  output ccon_pkg::rsp_t              rsp_o
);
  import ccon_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int CW = $clog2(MAX_COLS + 1);

  cmd_t          front_cmd, queue_cmd;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic          queue_valid, queue_full, pop, clearing, push;

  assign busy = queue_full || clearing;
  assign push = start && !busy;

  ccon_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_o      (front_cmd),
    .nr_o       (nr),
    .nc_o       (nc)
  );

  ccon_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .valid_o(queue_valid),
    .full_o (queue_full)
  );

  ccon_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nr_i       (nr),
    .nc_i       (nc),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule

/* rtl/ccon_fifo.sv */
module ccon_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccon_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output ccon_pkg::cmd_t cmd_o,
  output logic          valid_o,
  output logic          full_o
);
  import ccon_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          entry_q [QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10: cnt_d = cnt_q + NW'(1);
      2'b01: cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/ccon_front.sv */
module ccon_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  localparam int RW = $clog2(MAX_ROWS + 2),
  localparam int CW = $clog2(MAX_COLS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccon_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [ccon_pkg::CFG_DW-1:0]   cfg_wdata_i,
  input  ccon_pkg::req_t                req_i,
  output ccon_pkg::cmd_t                cmd_o,
  output logic [RW-1:0]                 nr_o,
  output logic [CW-1:0]                 nc_o
);
  import ccon_pkg::*;

  logic [6:0] rows_q;
  logic [7:0] cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ROWS: rows_q <= cfg_wdata_i[6:0];
        REG_COLS: cols_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // clamp counts into the store
  always_comb begin
    if (rows_q == '0) begin
      nr_o = RW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      nr_o = RW'(MAX_ROWS);
    end else begin
      nr_o = RW'(rows_q);
    end
    if (cols_q == '0) begin
      nc_o = CW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      nc_o = CW'(MAX_COLS);
    end else begin
      nc_o = CW'(cols_q);
    end
  end

  // classify the item
  always_comb begin
    cmd_o.char_code = req_i.char_code;
    cmd_o.read_row  = req_i.read_row;
    cmd_o.read_col  = req_i.read_col;
    if (req_i.req_type) begin
      cmd_o.op = OP_READ;
    end else begin
      case (req_i.char_code)
        CH_NUL:  cmd_o.op = OP_NUL;
        CH_CR:   cmd_o.op = OP_CR;
        CH_LF:   cmd_o.op = OP_LF;
        CH_BS:   cmd_o.op = OP_BS;
        CH_FF:   cmd_o.op = OP_FF;
        default: cmd_o.op = OP_CHAR;
      endcase
    end
  end

endmodule

/* rtl/ccon_back.sv */
module ccon_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  localparam int RW = $clog2(MAX_ROWS + 2),
  localparam int CW = $clog2(MAX_COLS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [RW-1:0]  nr_i,
  input  logic [CW-1:0]  nc_i,
  input  logic           cmd_valid_i,
  input  ccon_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           done_o,
  output ccon_pkg::rsp_t rsp_o
);
  import ccon_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_SCR_RD = 4'd4;
  localparam logic [3:0] S_SCR_WR = 4'd5;
  localparam logic [3:0] S_PUT    = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  logic [7:0]    store_mem [DEPTH];
  logic [7:0]    rdata_q;

  logic [3:0]    state_q, state_d, ret_q, ret_d;
  op_e           op_q, op_d;
  logic [7:0]    ch_q, ch_d, cell_q, cell_d;
  logic [RW-1:0] row_q, row_d, fr_q, fr_d, fr_last_q, fr_last_d;
  logic [CW-1:0] col_q, col_d, fc_q, fc_d, fc_first_q, fc_first_d, fc_last_q, fc_last_d;
  logic          scr_q, scr_d;
  logic [RW-1:0] bs_row;
  logic [CW-1:0] bs_col;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  // backspace target
  always_comb begin
    bs_row = row_q;
    bs_col = col_q - CW'(1);
    if (col_q == '0) begin
      bs_col = '0;
      if (row_q != '0) begin
        bs_row = row_q - RW'(1);
        bs_col = nc_i - CW'(1);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    op_d       = op_q;
    ch_d       = ch_q;
    cell_d     = cell_q;
    row_d      = row_q;
    col_d      = col_q;
    fr_d       = fr_q;
    fc_d       = fc_q;
    fr_last_d  = fr_last_q;
    fc_first_d = fc_first_q;
    fc_last_d  = fc_last_q;
    scr_d      = scr_q;
    pop_o      = 1'b0;
    we         = 1'b0;
    wa         = '0;
    wd         = CH_SP;
    re         = 1'b0;
    ra         = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o  = 1'b1;
          op_d   = cmd_i.op;
          ch_d   = cmd_i.char_code;
          scr_d  = 1'b0;
          cell_d = 8'h00;
          if (cmd_i.op == OP_READ) begin
            if ((int'(cmd_i.read_row) < MAX_ROWS) && (int'(cmd_i.read_col) < MAX_COLS)) begin
              re      = 1'b1;
              ra      = AW'(int'(cmd_i.read_row) * MAX_COLS + int'(cmd_i.read_col));
              state_d = S_READ;
            end else begin
              cell_d  = CH_SP;
              state_d = S_DONE;
            end
          end else begin
            if (col_q >= nc_i) begin
              col_d = nc_i - CW'(1);
            end
            if (row_q > nr_i) begin
              row_d = nr_i;
            end
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d = S_CHK;
        case (op_q)
          OP_CR: begin
            if (col_q == '0) begin
              if (row_q != '0) begin
                row_d = row_q - RW'(1);
              end
            end else begin
              col_d = '0;
            end
          end
          OP_LF: begin
            if (row_q < nr_i) begin
              fr_d       = row_q;
              fr_last_d  = row_q;
              fc_d       = col_q;
              fc_first_d = col_q;
              fc_last_d  = nc_i - CW'(1);
              ret_d      = S_CHK;
              state_d    = S_FILL;
            end
            col_d = '0;
            row_d = row_q + RW'(1);
          end
          OP_BS: begin
            row_d = bs_row;
            col_d = bs_col;
            if (bs_row < nr_i) begin
              fr_d       = bs_row;
              fr_last_d  = bs_row;
              fc_d       = bs_col;
              fc_first_d = bs_col;
              fc_last_d  = bs_col;
              ret_d      = S_CHK;
              state_d    = S_FILL;
            end
          end
          OP_FF: begin
            fr_d       = '0;
            fr_last_d  = nr_i - RW'(1);
            fc_d       = '0;
            fc_first_d = '0;
            fc_last_d  = nc_i - CW'(1);
            ret_d      = S_CHK;
            state_d    = S_FILL;
            row_d      = '0;
            col_d      = '0;
          end
          default: ;
        endcase
      end
      S_CHK: begin
        if (row_q >= nr_i) begin
          scr_d = 1'b1;
          row_d = nr_i - RW'(1);
          col_d = '0;
          if (nr_i > RW'(1)) begin
            fr_d    = RW'(1);
            fc_d    = '0;
            state_d = S_SCR_RD;
          end else begin
            fr_d       = nr_i - RW'(1);
            fr_last_d  = nr_i - RW'(1);
            fc_d       = '0;
            fc_first_d = '0;
            fc_last_d  = nc_i - CW'(1);
            ret_d      = S_PUT;
            state_d    = S_FILL;
          end
        end else begin
          state_d = S_PUT;
        end
      end
      S_SCR_RD: begin
        re      = 1'b1;
        ra      = cell_addr(fr_q, fc_q);
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        we      = 1'b1;
        wa      = cell_addr(fr_q - RW'(1), fc_q);
        wd      = rdata_q;
        state_d = S_SCR_RD;
        if (fc_q == nc_i - CW'(1)) begin
          fc_d = '0;
          if (fr_q == nr_i - RW'(1)) begin
            // blank the bottom row
            fr_d       = nr_i - RW'(1);
            fr_last_d  = nr_i - RW'(1);
            fc_first_d = '0;
            fc_last_d  = nc_i - CW'(1);
            ret_d      = S_PUT;
            state_d    = S_FILL;
          end else begin
            fr_d = fr_q + RW'(1);
          end
        end else begin
          fc_d = fc_q + CW'(1);
        end
      end
      S_FILL: begin
        we = 1'b1;
        wa = cell_addr(fr_q, fc_q);
        wd = CH_SP;
        if (fc_q == fc_last_q) begin
          if (fr_q == fr_last_q) begin
            state_d = ret_q;
          end else begin
            fr_d = fr_q + RW'(1);
            fc_d = fc_first_q;
          end
        end else begin
          fc_d = fc_q + CW'(1);
        end
      end
      S_PUT: begin
        if (op_q == OP_CHAR) begin
          we = 1'b1;
          wa = cell_addr(row_q, col_q);
          wd = ch_q;
          if (col_q == nc_i - CW'(1)) begin
            col_d = '0;
            row_d = row_q + RW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
        state_d = S_DONE;
      end
      S_READ: begin
        cell_d  = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts a sweep that blanks the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL;
      ret_q      <= S_IDLE;
      op_q       <= OP_NUL;
      row_q      <= '0;
      col_q      <= '0;
      fr_q       <= '0;
      fc_q       <= '0;
      fr_last_q  <= RW'(MAX_ROWS - 1);
      fc_first_q <= '0;
      fc_last_q  <= CW'(MAX_COLS - 1);
      scr_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      op_q       <= op_d;
      row_q      <= row_d;
      col_q      <= col_d;
      fr_q       <= fr_d;
      fc_q       <= fc_d;
      fr_last_q  <= fr_last_d;
      fc_first_q <= fc_first_d;
      fc_last_q  <= fc_last_d;
      scr_q      <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= store_mem[ra];
    end
  end

  assign clearing_o       = (state_q == S_FILL) && (ret_q == S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign rsp_o.cursor_row = 7'(row_q);
  assign rsp_o.cursor_col = 7'(col_q);
  assign rsp_o.cell_char  = cell_q;
  assign rsp_o.scrolled   = scr_q;

endmodule

/* rtl/ccon_chk.sv */
`include "assert_macros.svh"

module ccon_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy,
  input logic           done_o,
  input ccon_pkg::rsp_t rsp_o
);

  logic scroll_rsp_ok;

  assign scroll_rsp_ok = (rsp_o.cell_char == 8'h00) &&
                         ((rsp_o.cursor_col == 7'd0) || (rsp_o.cursor_col == 7'd1));

  `ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_IMP(a_busy_after_reset, clk_i, rst_ni, $rose(rst_ni), busy)
  `ASSERT_IMP(a_scroll_rsp, clk_i, rst_ni, done_o && rsp_o.scrolled, scroll_rsp_ok)

endmodule

bind text_console_char_engine ccon_chk u_chk (.*);
